// ===== design/bgd_pkg.sv =====
package bgd_pkg;

  // Defaults and fixed limits
  localparam int NUM_BTNS_DEF = 8;
  localparam int MAX_RESULTS  = 8;
  localparam int CNT_W        = $clog2(MAX_RESULTS + 1);

  localparam logic [15:0] LONG_TICKS_RST   = 16'd1000;
  localparam logic [15:0] DCLICK_TICKS_RST = 16'd300;

  // Register index (paddr word bit)
  localparam logic REG_LONG   = 1'b0;
  localparam logic REG_DCLICK = 1'b1;

  // Per-button gesture state codes
  typedef enum logic [2:0] {
    GST_IDLE       = 3'd0,
    GST_PRESSED    = 3'd1,
    GST_CLICK_WAIT = 3'd2,
    GST_PRESSED2   = 3'd3,
    GST_LONG       = 3'd4
  } gst_e;

  // Event codes on the output
  typedef enum logic [2:0] {
    EV_PRESSED  = 3'd0,
    EV_RELEASED = 3'd1,
    EV_SINGLE   = 3'd2,
    EV_DOUBLE   = 3'd3,
    EV_LONG     = 3'd4
  } ev_kind_e;

  // One button's entry in the state memory; all zero is the reset value
  typedef struct packed {
    logic [2:0]  gstate;
    logic        prev;
    logic [31:0] count;
    logic [31:0] ptime;
    logic [31:0] rtime;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  // Outcome of evaluating one entry
  typedef struct packed {
    logic        fire;
    ev_kind_e    kind;
    logic        dbl;
    logic [31:0] dur;
  } eval_t;

endpackage

// ===== design/button_gesture_detector_unit.sv =====
// Level change: read the entry, evaluate it, push a double event if one fires, then flush the last event.
// Tick: the scan reads one button entry from the state RAM per cycle unless output back-pressure stalls it.
// One item in flight at a time; output back-pressure stalls both evaluation and flush.
// Reset clears time and per-entry valid bits and sets config to 1000 / 300 ticks; entries
// not yet written read as idle with zero counts and times.
module button_gesture_detector_unit #(
  parameter int NUM_BTNS = bgd_pkg::NUM_BTNS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // request channel
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        req_type_i,
  input  logic [2:0]  button_index_i,
  input  logic        pressed_level_i,
  // event channel
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [2:0]  event_kind_o,
  output logic [2:0]  button_id_o,
  output logic [31:0] duration_o,
  output logic [31:0] press_total_o,
  output logic [31:0] time_stamp_o,
  output logic        last_event_o,
  // configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import bgd_pkg::*;

  localparam int AddrW = (NUM_BTNS > 1) ? $clog2(NUM_BTNS) : 1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LC_EVAL,
    ST_LC_DBL,
    ST_TK_EVAL,
    ST_FLUSH
  } state_e;

  typedef struct packed {
    ev_kind_e    kind;
    logic [2:0]  btn;
    logic [31:0] dur;
    logic [31:0] total;
    logic [31:0] stamp;
  } event_t;

  state_e            state_q;
  logic [15:0]       long_ticks_q;
  logic [15:0]       dclick_ticks_q;
  logic [31:0]       time_q;
  logic [AddrW-1:0]  idx_q;
  logic [CNT_W-1:0]  cnt_q;
  logic              lvl_q;
  logic [NUM_BTNS-1:0] vld_q;
  logic              rd_vld_q;
  event_t            stg_q;
  logic              stg_v_q;
  event_t            out_q;
  logic              out_valid_q;
  logic              out_last_q;

  logic              out_free;
  logic              can_push;
  logic              in_range;
  logic              in_xfer;
  logic              go;
  logic              scan_done;
  logic              push;
  logic              flush;
  event_t            push_ev;
  event_t            new_ev;
  event_t            dbl_ev;
  entry_t            ent;
  entry_t            nxt;
  eval_t             res;
  logic              ram_we;
  logic              ram_re;
  logic [AddrW-1:0]  ram_waddr;
  logic [AddrW-1:0]  ram_raddr;
  logic [ENTRY_W-1:0] ram_rdata;

  // Config port
  assign pready = 1'b1;
  always_comb begin
    if (paddr[2] == REG_DCLICK) begin
      prdata = {16'd0, dclick_ticks_q};
    end else begin
      prdata = {16'd0, long_ticks_q};
    end
  end

  // Handshake helpers
  assign in_ready_o = (state_q == ST_IDLE);
  assign in_xfer    = in_valid_i && in_ready_o;
  assign in_range   = (32'(button_index_i) < NUM_BTNS);
  assign out_free   = !out_valid_q || out_ready_i;
  assign can_push   = !stg_v_q || out_free;

  // Entry as read; unwritten entries look like reset
  assign ent = rd_vld_q ? entry_t'(ram_rdata) : '0;

  bgd_eval u_eval (
    .is_tick_i      (state_q == ST_TK_EVAL),
    .level_i        (lvl_q),
    .time_i         (time_q),
    .long_ticks_i   (long_ticks_q),
    .dclick_ticks_i (dclick_ticks_q),
    .cur_i          (ent),
    .nxt_o          (nxt),
    .res_o          (res)
  );

  // Event candidates
  always_comb begin
    new_ev.kind  = res.kind;
    new_ev.btn   = 3'(idx_q);
    new_ev.dur   = res.dur;
    new_ev.total = nxt.count;
    new_ev.stamp = time_q;
    dbl_ev       = stg_q;
    dbl_ev.kind  = EV_DOUBLE;
    push_ev      = (state_q == ST_LC_DBL) ? dbl_ev : new_ev;
  end

  // Memory access and sequencing control
  assign go        = !res.fire || can_push;
  assign scan_done = (idx_q == AddrW'(NUM_BTNS - 1)) ||
                     (res.fire && (cnt_q == CNT_W'(MAX_RESULTS - 1)));
  assign ram_we    = ((state_q == ST_LC_EVAL) && can_push) ||
                     ((state_q == ST_TK_EVAL) && res.fire && can_push);
  assign ram_waddr = idx_q;
  assign ram_re    = (in_xfer && (req_type_i || in_range)) ||
                     ((state_q == ST_TK_EVAL) && go && !scan_done);
  assign ram_raddr = (state_q == ST_IDLE) ? (req_type_i ? '0 : AddrW'(button_index_i))
                                          : idx_q + AddrW'(1);
  assign push      = (((state_q == ST_LC_EVAL) || (state_q == ST_TK_EVAL)) &&
                      res.fire && can_push) ||
                     ((state_q == ST_LC_DBL) && can_push);
  assign flush     = (state_q == ST_FLUSH) && stg_v_q && out_free;

  bgd_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (NUM_BTNS)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (nxt),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // State machine, staging and output registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= ST_IDLE;
      long_ticks_q   <= LONG_TICKS_RST;
      dclick_ticks_q <= DCLICK_TICKS_RST;
      time_q         <= '0;
      idx_q          <= '0;
      cnt_q          <= '0;
      lvl_q          <= 1'b0;
      vld_q          <= '0;
      rd_vld_q       <= 1'b0;
      stg_v_q        <= 1'b0;
      out_valid_q    <= 1'b0;
      out_last_q     <= 1'b0;
    end else begin
      // register writes
      if (psel && penable && pwrite) begin
        if (paddr[2] == REG_DCLICK) begin
          dclick_ticks_q <= pwdata[15:0];
        end else begin
          long_ticks_q <= pwdata[15:0];
        end
      end

      // entry valid tracking
      if (ram_we) begin
        vld_q[idx_q] <= 1'b1;
      end
      if (ram_re) begin
        rd_vld_q <= vld_q[ram_raddr];
      end

      // output transfer
      if ((push && stg_v_q) || flush) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (push) begin
        if (stg_v_q) begin
          out_q      <= stg_q;
          out_last_q <= 1'b0;
        end
        stg_q   <= push_ev;
        stg_v_q <= 1'b1;
      end
      if (flush) begin
        out_q      <= stg_q;
        out_last_q <= 1'b1;
        stg_v_q    <= 1'b0;
      end

      case (state_q)
        ST_IDLE: begin
          if (in_valid_i) begin
            lvl_q <= pressed_level_i;
            if (req_type_i) begin
              time_q  <= time_q + 32'd1;
              idx_q   <= '0;
              cnt_q   <= '0;
              state_q <= ST_TK_EVAL;
            end else if (in_range) begin
              idx_q   <= AddrW'(button_index_i);
              state_q <= ST_LC_EVAL;
            end
          end
        end
        ST_LC_EVAL: begin
          if (can_push) begin
            state_q <= (res.fire && res.dbl) ? ST_LC_DBL : ST_FLUSH;
          end
        end
        ST_LC_DBL: begin
          if (can_push) begin
            state_q <= ST_FLUSH;
          end
        end
        ST_TK_EVAL: begin
          if (go) begin
            if (res.fire) begin
              cnt_q <= cnt_q + CNT_W'(1);
            end
            if (scan_done) begin
              state_q <= ST_FLUSH;
            end else begin
              idx_q <= idx_q + AddrW'(1);
            end
          end
        end
        ST_FLUSH: begin
          if (!stg_v_q || out_free) begin
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  // Output ports
  assign out_valid_o   = out_valid_q;
  assign event_kind_o  = out_q.kind;
  assign button_id_o   = out_q.btn;
  assign duration_o    = out_q.dur;
  assign press_total_o = out_q.total;
  assign time_stamp_o  = out_q.stamp;
  assign last_event_o  = out_last_q;

  // Checks
  a_tick_advances_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_xfer && req_type_i) |=> (time_q == $past(time_q) + 32'd1))
    else $error("time counter did not advance on tick");

  a_idle_stage_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE) |-> !stg_v_q)
    else $error("staged event left behind at end of item");

  a_event_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_W'(MAX_RESULTS))
    else $error("tick produced too many events");

  a_no_rw_same_entry: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ram_we && ram_re) |-> (ram_waddr != ram_raddr))
    else $error("read and write of the same entry in one cycle");

endmodule

// ===== design/bgd_ram.sv =====
module bgd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

// ===== design/bgd_eval.sv =====
module bgd_eval (
  input  logic           is_tick_i,
  input  logic           level_i,
  input  logic [31:0]    time_i,
  input  logic [15:0]    long_ticks_i,
  input  logic [15:0]    dclick_ticks_i,
  input  bgd_pkg::entry_t cur_i,
  output bgd_pkg::entry_t nxt_o,
  output bgd_pkg::eval_t  res_o
);
  import bgd_pkg::*;

  logic        rise;
  logic        fall;
  logic [31:0] press_dt;
  logic [31:0] rel_dt;

  assign rise     = level_i & ~cur_i.prev;
  assign fall     = ~level_i & cur_i.prev;
  assign press_dt = time_i - cur_i.ptime;
  assign rel_dt   = time_i - cur_i.rtime;

  // Next entry and event for a tick deadline check or a level change
  always_comb begin
    nxt_o = cur_i;
    res_o = '0;
    if (is_tick_i) begin
      case (cur_i.gstate)
        GST_PRESSED: begin
          if (press_dt >= {16'd0, long_ticks_i}) begin
            nxt_o.rtime  = time_i;
            nxt_o.gstate = GST_LONG;
            res_o.fire   = 1'b1;
            res_o.kind   = EV_LONG;
            res_o.dur    = {16'd0, long_ticks_i};
          end
        end
        GST_CLICK_WAIT: begin
          if (rel_dt >= {16'd0, dclick_ticks_i}) begin
            nxt_o.gstate = GST_IDLE;
            res_o.fire   = 1'b1;
            res_o.kind   = EV_SINGLE;
            res_o.dur    = cur_i.rtime - cur_i.ptime;
          end
        end
        default: ;
      endcase
    end else begin
      nxt_o.prev = level_i;
      case (cur_i.gstate)
        GST_PRESSED: begin
          if (fall) begin
            nxt_o.rtime  = time_i;
            nxt_o.gstate = GST_CLICK_WAIT;
            res_o.fire   = 1'b1;
            res_o.kind   = EV_RELEASED;
            res_o.dur    = press_dt;
          end
        end
        GST_CLICK_WAIT: begin
          if (rise) begin
            nxt_o.count  = cur_i.count + 32'd1;
            nxt_o.ptime  = time_i;
            nxt_o.gstate = GST_PRESSED2;
            res_o.fire   = 1'b1;
            res_o.kind   = EV_PRESSED;
          end
        end
        GST_PRESSED2: begin
          if (fall) begin
            nxt_o.gstate = GST_IDLE;
            res_o.fire   = 1'b1;
            res_o.kind   = EV_RELEASED;
            res_o.dbl    = 1'b1;
            res_o.dur    = press_dt;
          end
        end
        GST_LONG: begin
          if (fall) begin
            nxt_o.gstate = GST_IDLE;
            res_o.fire   = 1'b1;
            res_o.kind   = EV_RELEASED;
            res_o.dur    = press_dt;
          end
        end
        // idle and unused codes
        default: begin
          if (rise) begin
            nxt_o.count  = cur_i.count + 32'd1;
            nxt_o.ptime  = time_i;
            nxt_o.gstate = GST_PRESSED;
            res_o.fire   = 1'b1;
            res_o.kind   = EV_PRESSED;
          end
        end
      endcase
    end
  end

endmodule
